// File: rtl/dle_pkg.sv
// Shared types and constants for the discrete Laplacian block.
`timescale 1ns / 1ps
package dle_pkg;

  localparam int DATA_W       = 32;
  localparam int IDX_W        = 6;
  localparam int CFG_W        = 7;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam int TERM_W       = 36;
  localparam int ACC_W        = 38;
  localparam int SHIFT        = 2;
  localparam int MIN_SIZE     = 4;
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;
  localparam int STEP_W       = 3;

  localparam logic [CFG_W-1:0]  RESET_SIZE = 7'd64;
  localparam logic [STEP_W-1:0] LAST_STEP  = 3'd6;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    COEF_ZERO,
    COEF_P1,
    COEF_M1,
    COEF_P4,
    COEF_M4,
    COEF_M5
  } coef_t;

  typedef struct packed {
    logic  clear;
    coef_t coef;
  } alu_ctl_t;

  typedef struct packed {
    logic load;
    logic status;
  } seq_res_t;

endpackage

// File: rtl/discrete_laplacian_edge_extrapolated_top.sv
// Top level: config registers, output register and the sample store.
// A write word gives no result; the input is ready again at once.
// A read inside the matrix walks seven fetches through the single store port, then a
// drain state, then a load of the output register once that register is free.
// A read outside the configured size skips the fetches and loads a zero result with status set.
// The input stalls while a read is in flight; one finished word may wait at the output.
// Reset (synchronous, rst_n low) sets both sizes to 64 and clears control state only.
`timescale 1ns / 1ps
module discrete_laplacian_edge_extrapolated_top #(
  parameter int MAX_ROWS = dle_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = dle_pkg::MAX_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [dle_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [dle_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [dle_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic [dle_pkg::IDX_W-1:0]          in_row_index,
  input  logic [dle_pkg::IDX_W-1:0]          in_col_index,
  input  logic signed [dle_pkg::DATA_W-1:0]  in_sample_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dle_pkg::DATA_W-1:0]  out_laplacian_value,
  output logic                               out_status
);
  import dle_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NRW   = $clog2(MAX_ROWS+1);
  localparam int NCW   = $clog2(MAX_COLS+1);
  localparam int SRW   = (NRW > CFG_W) ? NRW : CFG_W;
  localparam int SCW   = (NCW > CFG_W) ? NCW : CFG_W;
  localparam int OVF_W = ACC_W - DATA_W - SHIFT + 1;

  logic [CFG_W-1:0]         rows_r, cols_r;
  logic                     cfg_wr;
  logic [NRW-1:0]           eff_rows;
  logic [NCW-1:0]           eff_cols;
  logic [SRW-1:0]           rows_x;
  logic [SCW-1:0]           cols_x;

  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [DATA_W-1:0]        ram_rdata;
  alu_ctl_t                 alu_ctl;
  seq_res_t                 res;
  logic signed [ACC_W-1:0]  acc;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_status_r, out_status_nxt;
  logic                     out_free;
  logic [OVF_W-1:0]         ovf_bits;
  logic signed [DATA_W-1:0] sat_value;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= RESET_SIZE;
      cols_r <= RESET_SIZE;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_ROWS: rows_r <= cfg_pwdata[CFG_W-1:0];
        REG_COLS: cols_r <= cfg_pwdata[CFG_W-1:0];
        default:  rows_r <= rows_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_ROWS: cfg_prdata = CFG_DW'(rows_r);
      REG_COLS: cfg_prdata = CFG_DW'(cols_r);
      default:  cfg_prdata = '0;
    endcase
  end

  assign rows_x = SRW'(rows_r);
  assign cols_x = SCW'(cols_r);

  always_comb begin
    if (rows_x < SRW'(MIN_SIZE)) begin
      eff_rows = NRW'(MIN_SIZE);
    end else if (rows_x > SRW'(MAX_ROWS)) begin
      eff_rows = NRW'(MAX_ROWS);
    end else begin
      eff_rows = NRW'(rows_x);
    end
    if (cols_x < SCW'(MIN_SIZE)) begin
      eff_cols = NCW'(MIN_SIZE);
    end else if (cols_x > SCW'(MAX_COLS)) begin
      eff_cols = NCW'(MAX_COLS);
    end else begin
      eff_cols = NCW'(cols_x);
    end
  end

  dle_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .eff_rows        (eff_rows),
    .eff_cols        (eff_cols),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_sample_value (in_sample_value),
    .ram_we          (ram_we),
    .ram_addr        (ram_addr),
    .ram_wdata       (ram_wdata),
    .alu_ctl         (alu_ctl),
    .out_free        (out_free),
    .res             (res)
  );

  dle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  dle_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .rdata (ram_rdata),
    .acc   (acc)
  );

  // Floor divide by 4, then clamp to 32 bits.
  assign ovf_bits = acc[ACC_W-1:DATA_W+SHIFT-1];

  always_comb begin
    if ((&ovf_bits) || !(|ovf_bits)) begin
      sat_value = acc[DATA_W+SHIFT-1:SHIFT];
    end else if (acc[ACC_W-1]) begin
      sat_value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res.load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res.status;
      out_value_nxt  = res.status ? '0 : sat_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_laplacian_value = out_value_r;
  assign out_status          = out_status_r;

endmodule

// File: rtl/dle_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module dle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/dle_alu.sv
// Shared scale-and-accumulate unit for the stencil terms.
`timescale 1ns / 1ps
module dle_alu (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dle_pkg::alu_ctl_t                 ctl,
  input  logic [dle_pkg::DATA_W-1:0]        rdata,
  output logic signed [dle_pkg::ACC_W-1:0]  acc
);
  import dle_pkg::*;

  coef_t                    coef_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [DATA_W-1:0] ds;
  logic signed [TERM_W-1:0] d1;
  logic signed [TERM_W-1:0] d4;
  logic signed [TERM_W-1:0] term;

  assign ds = signed'(rdata);
  assign d1 = TERM_W'(ds);
  assign d4 = d1 <<< 2;

  always_comb begin
    case (coef_r)
      COEF_P1: term = d1;
      COEF_M1: term = -d1;
      COEF_P4: term = d4;
      COEF_M4: term = -d4;
      COEF_M5: term = -d4 - d1;
      default: term = '0;
    endcase
    acc_nxt = ctl.clear ? '0 : acc_r + ACC_W'(term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_ZERO;
    end else begin
      coef_r <= ctl.coef;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// File: rtl/dle_seq.sv
// Sequencer: input handshake, sample writes and the seven-fetch stencil walk.
`timescale 1ns / 1ps
module dle_seq #(
  parameter int MAX_ROWS = dle_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = dle_pkg::MAX_COLS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [$clog2(MAX_ROWS+1)-1:0]         eff_rows,
  input  logic [$clog2(MAX_COLS+1)-1:0]         eff_cols,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_command,
  input  logic [dle_pkg::IDX_W-1:0]             in_row_index,
  input  logic [dle_pkg::IDX_W-1:0]             in_col_index,
  input  logic signed [dle_pkg::DATA_W-1:0]     in_sample_value,
  output logic                                  ram_we,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]  ram_addr,
  output logic [dle_pkg::DATA_W-1:0]            ram_wdata,
  output dle_pkg::alu_ctl_t                     alu_ctl,
  input  logic                                  out_free,
  output dle_pkg::seq_res_t                     res
);
  import dle_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int AW  = $clog2(MAX_ROWS*MAX_COLS);
  localparam int NRW = $clog2(MAX_ROWS+1);
  localparam int NCW = $clog2(MAX_COLS+1);
  localparam int RXW = (NRW > IDX_W) ? NRW : IDX_W;
  localparam int CXW = (NCW > IDX_W) ? NCW : IDX_W;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic              row_lo_r, row_lo_nxt, row_hi_r, row_hi_nxt;
  logic              col_lo_r, col_lo_nxt, col_hi_r, col_hi_nxt;
  logic              status_r, status_nxt;

  logic [RXW-1:0]    row_x;
  logic [CXW-1:0]    col_x;
  logic              in_range;
  logic              accept;
  logic              in_row_lo, in_row_hi, in_col_lo, in_col_hi;

  logic              axis_col;
  logic [1:0]        k;
  logic              e_lo, e_hi;
  logic signed [2:0] off, dr, dc;
  coef_t             step_coef;
  coef_t             center_coef;
  logic [RW-1:0]     row_sel;
  logic [CW-1:0]     col_sel;

  assign row_x     = RXW'(in_row_index);
  assign col_x     = CXW'(in_col_index);
  assign in_range  = (row_x < RXW'(eff_rows)) && (col_x < CXW'(eff_cols));
  assign accept    = (state_r == S_IDLE) && in_valid;
  assign in_stall  = (state_r != S_IDLE);
  assign in_row_lo = (row_x == '0);
  assign in_row_hi = (row_x == RXW'(eff_rows) - RXW'(1));
  assign in_col_lo = (col_x == '0);
  assign in_col_hi = (col_x == CXW'(eff_cols) - CXW'(1));

  // Center weight sums both axes, -2 inside and +2 on a border line each.
  always_comb begin
    if ((row_lo_r || row_hi_r) && (col_lo_r || col_hi_r)) begin
      center_coef = COEF_P4;
    end else if (!(row_lo_r || row_hi_r) && !(col_lo_r || col_hi_r)) begin
      center_coef = COEF_M4;
    end else begin
      center_coef = COEF_ZERO;
    end
  end

  // Steps 1-3 walk the row axis, 4-6 the column axis.
  always_comb begin
    axis_col = (step_r > 3'd3);
    k        = axis_col ? 2'(step_r - 3'd3) : step_r[1:0];
    e_lo     = axis_col ? col_lo_r : row_lo_r;
    e_hi     = axis_col ? col_hi_r : row_hi_r;
    case (k)
      2'd1: begin
        off       = e_lo ? 3'sd1 : -3'sd1;
        step_coef = (e_lo || e_hi) ? COEF_M5 : COEF_P1;
      end
      2'd2: begin
        off       = e_lo ? 3'sd2 : (e_hi ? -3'sd2 : 3'sd1);
        step_coef = (e_lo || e_hi) ? COEF_P4 : COEF_P1;
      end
      2'd3: begin
        off       = e_lo ? 3'sd3 : (e_hi ? -3'sd3 : 3'sd0);
        step_coef = (e_lo || e_hi) ? COEF_M1 : COEF_ZERO;
      end
      default: begin
        off       = 3'sd0;
        step_coef = center_coef;
      end
    endcase
    dr = axis_col ? 3'sd0 : off;
    dc = axis_col ? off : 3'sd0;
  end

  always_comb begin
    if (state_r == S_IDLE) begin
      row_sel = RW'(in_row_index);
      col_sel = CW'(in_col_index);
    end else begin
      row_sel = row_r + RW'(dr);
      col_sel = col_r + CW'(dc);
    end
  end

  assign ram_addr  = AW'(row_sel) * AW'(MAX_COLS) + AW'(col_sel);
  assign ram_wdata = in_sample_value;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    row_lo_nxt    = row_lo_r;
    row_hi_nxt    = row_hi_r;
    col_lo_nxt    = col_lo_r;
    col_hi_nxt    = col_hi_r;
    status_nxt    = status_r;
    ram_we        = 1'b0;
    alu_ctl.clear = 1'b0;
    alu_ctl.coef  = COEF_ZERO;
    res.load      = 1'b0;
    res.status    = status_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_WRITE) begin
            ram_we = in_range;
          end else if (in_range) begin
            alu_ctl.clear = 1'b1;
            step_nxt      = '0;
            row_nxt       = RW'(in_row_index);
            col_nxt       = CW'(in_col_index);
            row_lo_nxt    = in_row_lo;
            row_hi_nxt    = in_row_hi;
            col_lo_nxt    = in_col_lo;
            col_hi_nxt    = in_col_hi;
            status_nxt    = 1'b0;
            state_nxt     = S_RUN;
          end else begin
            status_nxt = 1'b1;
            state_nxt  = S_DONE;
          end
        end
      end
      S_RUN: begin
        alu_ctl.coef = step_coef;
        if (step_r == LAST_STEP) begin
          state_nxt = S_DRAIN;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          res.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= '0;
      status_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    row_lo_r <= row_lo_nxt;
    row_hi_r <= row_hi_nxt;
    col_lo_r <= col_lo_nxt;
    col_hi_r <= col_hi_nxt;
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> out_free) else $error("result loaded over a waiting word");

  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE) && in_valid) else $error("store written while busy");

  a_read_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == CMD_READ) && in_range) |=> (state_r == S_RUN) && (step_r == '0))
    else $error("read did not start the fetch walk");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RUN) && (step_r == LAST_STEP)) |=> (state_r == S_DRAIN))
    else $error("fetch walk did not drain");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> (state_r == S_DONE)) else $error("drain overran");

endmodule

// File: dv/discrete_laplacian_edge_extrapolated_top_tb.sv
// Self-checking testbench for the discrete Laplacian block: directed table, then random phases.
`timescale 1ns / 1ps
module discrete_laplacian_edge_extrapolated_top_tb;
  import dle_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     status;
  } lap_word_t;

  typedef enum logic {ROW_WORD, ROW_CFG} dir_kind_t;

  typedef struct packed {
    dir_kind_t          kind;
    logic               cmd;
    logic               reg_sel;
    logic [IDX_W-1:0]   r;
    logic [IDX_W-1:0]   c;
    logic [DATA_W-1:0]  data;
    logic               typed;
    logic [DATA_W-1:0]  exp_value;
    logic               exp_status;
  } dir_row_t;

  localparam int N_DIR    = 20;
  localparam int N_PHASE  = 12;
  localparam int PHASE_WORDS = 80;
  localparam int SETTLE   = 16;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_psel;
  logic                      cfg_penable;
  logic                      cfg_pwrite;
  logic [CFG_AW-1:0]         cfg_paddr;
  logic [CFG_DW-1:0]         cfg_pwdata;
  logic [CFG_DW-1:0]         cfg_prdata;
  logic                      cfg_pready;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_command;
  logic [IDX_W-1:0]          in_row_index;
  logic [IDX_W-1:0]          in_col_index;
  logic signed [DATA_W-1:0]  in_sample_value;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DATA_W-1:0]  out_laplacian_value;
  logic                      out_status;

  discrete_laplacian_edge_extrapolated_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_row_index        (in_row_index),
    .in_col_index        (in_col_index),
    .in_sample_value     (in_sample_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_laplacian_value (out_laplacian_value),
    .out_status          (out_status)
  );

  // shadow of the block state
  logic signed [DATA_W-1:0] sample_mem [MAX_ROWS_DEF][MAX_COLS_DEF];
  bit                       sample_set [MAX_ROWS_DEF][MAX_COLS_DEF];
  logic [CFG_W-1:0]         rows_reg;
  logic [CFG_W-1:0]         cols_reg;
  lap_word_t                lap_expected [$];

  bit idle_on = 1'b1;
  int stall_left = 0;
  int errors = 0;
  int words_in = 0;
  int reads_in = 0;
  int writes_in = 0;
  int cfg_writes = 0;
  int results_checked = 0;
  int outside_seen = 0;
  int saturated_seen = 0;

  dir_row_t dir_table [N_DIR] = '{
    '{ROW_WORD, CMD_WRITE, REG_ROWS, 6'd0,  6'd0,  32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD, CMD_WRITE, REG_ROWS, 6'd1,  6'd0,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD, CMD_WRITE, REG_ROWS, 6'd2,  6'd0,  32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD, CMD_WRITE, REG_ROWS, 6'd3,  6'd0,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD, CMD_WRITE, REG_ROWS, 6'd0,  6'd1,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD, CMD_WRITE, REG_ROWS, 6'd0,  6'd2,  32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD, CMD_WRITE, REG_ROWS, 6'd0,  6'd3,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
    // corner with alternating extremes: clamps high
    '{ROW_WORD, CMD_READ,  REG_ROWS, 6'd0,  6'd0,  32'h0,  1'b1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_WORD, CMD_WRITE, REG_ROWS, 6'd63, 6'd63, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG,  CMD_WRITE, REG_ROWS, 6'd0,  6'd0,  32'd0,   1'b0, 32'h0, 1'b0},
    '{ROW_CFG,  CMD_WRITE, REG_COLS, 6'd0,  6'd0,  32'd127, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD, CMD_READ,  REG_ROWS, 6'd4,  6'd0,  32'h0,  1'b1, 32'h0, 1'b1},
    '{ROW_WORD, CMD_READ,  REG_ROWS, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1},
    '{ROW_WORD, CMD_WRITE, REG_ROWS, 6'd5,  6'd5,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD, CMD_READ,  REG_ROWS, 6'd0,  6'd0,  32'h0,  1'b0, 32'h0, 1'b0},
    '{ROW_CFG,  CMD_WRITE, REG_ROWS, 6'd0,  6'd0,  32'd64,  1'b0, 32'h0, 1'b0},
    '{ROW_CFG,  CMD_WRITE, REG_COLS, 6'd0,  6'd0,  32'd3,   1'b0, 32'h0, 1'b0},
    '{ROW_WORD, CMD_READ,  REG_ROWS, 6'd0,  6'd4,  32'h0,  1'b1, 32'h0, 1'b1},
    '{ROW_WORD, CMD_READ,  REG_ROWS, 6'd0,  6'd63, 32'h0,  1'b1, 32'h0, 1'b1},
    '{ROW_WORD, CMD_WRITE, REG_ROWS, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0}
  };

  // rows and cols settings per random phase; only the low 7 bits are kept, and values beyond the legal range clamp
  logic [CFG_DW-1:0] phase_rows [N_PHASE] = '{32'd4, 32'd0, 32'd127, 32'd5, 32'd64, 32'd4,
                                              32'd7, 32'd65, 32'd12, 32'h105, 32'd64, 32'd6};
  logic [CFG_DW-1:0] phase_cols [N_PHASE] = '{32'd4, 32'd3, 32'd127, 32'd9, 32'd4, 32'd64,
                                              32'd6, 32'd2, 32'd10, 32'd8, 32'd64, 32'd5};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int eff_size(logic [CFG_W-1:0] v, int maxv);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic longint sample_at(int r, int c);
    return longint'(sample_mem[r][c]);
  endfunction

  // second difference along one axis, one-sided extrapolation on the border lines
  function automatic longint axis_d2(int r, int c, int dr, int dc, int p, int n);
    longint f0;
    f0 = sample_at(r, c);
    if (p == 0)
      return 2 * f0 - 5 * sample_at(r + dr, c + dc) + 4 * sample_at(r + 2 * dr, c + 2 * dc)
             - sample_at(r + 3 * dr, c + 3 * dc);
    if (p == n - 1)
      return 2 * f0 - 5 * sample_at(r - dr, c - dc) + 4 * sample_at(r - 2 * dr, c - 2 * dc)
             - sample_at(r - 3 * dr, c - 3 * dc);
    return sample_at(r - dr, c - dc) - 2 * f0 + sample_at(r + dr, c + dc);
  endfunction

  function automatic bit predict_laplacian(input logic cmd, input logic [IDX_W-1:0] r,
                                           input logic [IDX_W-1:0] c,
                                           input logic [DATA_W-1:0] v, output lap_word_t w);
    int nr;
    int nc;
    bit in_size;
    longint acc;
    nr = eff_size(rows_reg, MAX_ROWS_DEF);
    nc = eff_size(cols_reg, MAX_COLS_DEF);
    in_size = (int'(r) < nr) && (int'(c) < nc);
    w = '0;
    if (cmd == CMD_WRITE) begin
      if (in_size) begin
        sample_mem[r][c] = v;
        sample_set[r][c] = 1'b1;
      end
      return 1'b0;
    end
    if (!in_size) begin
      w.status = 1'b1;
      return 1'b1;
    end
    acc = axis_d2(int'(r), int'(c), 1, 0, int'(r), nr)
          + axis_d2(int'(r), int'(c), 0, 1, int'(c), nc);
    acc = acc >>> SHIFT;
    if (acc > 64'sd2147483647) w.value = 32'h7FFF_FFFF;
    else if (acc < -64'sd2147483648) w.value = 32'h8000_0000;
    else w.value = acc[31:0];
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4, 5: return $urandom;
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  // biased toward borders and corners
  function automatic int pick_pos(int n);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return n - 1;
      2: return 1;
      3: return n - 2;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  task automatic send_word(input logic cmd, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v,
                           input bit typed, input lap_word_t typed_word);
    lap_word_t w;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_row_index    <= r;
    in_col_index    <= c;
    in_sample_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_in++;
    if (cmd == CMD_READ) reads_in++;
    else writes_in++;
    if (predict_laplacian(cmd, r, c, v, w)) lap_expected.push_back(typed ? typed_word : w);
  endtask

  // store every sample the stencil at (r, c) reads that is not yet set, before the read goes out
  task automatic cover_needed(int r, int c, int nr, int nc);
    int lo;
    int hi;
    lo = (r == 0) ? 0 : (r == nr - 1) ? r - 3 : r - 1;
    hi = (r == 0) ? 3 : (r == nr - 1) ? r : r + 1;
    for (int i = lo; i <= hi; i++)
      if (!sample_set[i][c])
        send_word(CMD_WRITE, IDX_W'(i), IDX_W'(c), rand_sample(), 1'b0, '0);
    lo = (c == 0) ? 0 : (c == nc - 1) ? c - 3 : c - 1;
    hi = (c == 0) ? 3 : (c == nc - 1) ? c : c + 1;
    for (int i = lo; i <= hi; i++)
      if (!sample_set[r][i])
        send_word(CMD_WRITE, IDX_W'(r), IDX_W'(i), rand_sample(), 1'b0, '0);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    for (int i = 0; i < 4000 && lap_expected.size() != 0; i++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (sel == REG_ROWS) rows_reg = data[CFG_W-1:0];
    else cols_reg = data[CFG_W-1:0];
    cfg_writes++;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) stall_left = stall_left - 1;
    else if (idle_on && rst_n && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin : result_check
    lap_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lap_expected.size() == 0) begin
        $error("result word with none pending: laplacian_value %h status %b",
               out_laplacian_value, out_status);
        errors++;
      end else begin
        want = lap_expected.pop_front();
        results_checked++;
        if (out_laplacian_value !== want.value) begin
          $error("laplacian_value: expected %h, got %h", want.value, out_laplacian_value);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %b, got %b", want.status, out_status);
          errors++;
        end
        if (want.status) outside_seen++;
        else if (want.value == 32'h7FFF_FFFF || want.value == 32'h8000_0000) saturated_seen++;
      end
    end
  end

  initial begin
    #2_000_000;
    $error("run did not finish in time, %0d results pending", lap_expected.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int r;
    int c;
    int sel;
    int nr;
    int nc;
    int phase_end;
    dir_row_t row;
    lap_word_t typed_word;

    rst_n           <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    in_valid        <= 1'b0;
    in_command      <= CMD_WRITE;
    in_row_index    <= '0;
    in_col_index    <= '0;
    in_sample_value <= '0;
    rows_reg = RESET_SIZE;
    cols_reg = RESET_SIZE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      row = dir_table[i];
      if (row.kind == ROW_CFG) begin
        settle_block();
        cfg_write(row.reg_sel, row.data);
      end else begin
        typed_word.value  = row.exp_value;
        typed_word.status = row.exp_status;
        send_word(row.cmd, row.r, row.c, row.data, row.typed, typed_word);
      end
    end

    for (int ph = 0; ph < N_PHASE; ph++) begin
      settle_block();
      cfg_write(REG_ROWS, phase_rows[ph]);
      cfg_write(REG_COLS, phase_cols[ph]);
      idle_on = !(ph % 4 == 2 || ph == N_PHASE - 1);
      nr = eff_size(rows_reg, MAX_ROWS_DEF);
      nc = eff_size(cols_reg, MAX_COLS_DEF);
      phase_end = words_in + PHASE_WORDS;
      while (words_in < phase_end) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          r = pick_pos(nr);
          c = pick_pos(nc);
          cover_needed(r, c, nr, nc);
          send_word(CMD_READ, IDX_W'(r), IDX_W'(c), $urandom, 1'b0, '0);
        end else if (sel < 75) begin
          send_word(CMD_WRITE, IDX_W'($urandom_range(0, nr - 1)),
                    IDX_W'($urandom_range(0, nc - 1)), rand_sample(), 1'b0, '0);
        end else if (sel < 87) begin
          send_word(CMD_WRITE, IDX_W'($urandom_range(0, 63)), IDX_W'($urandom_range(0, 63)),
                    rand_sample(), 1'b0, '0);
        end else begin
          r = $urandom_range(0, 63);
          c = $urandom_range(0, 63);
          if (r < nr && c < nc) cover_needed(r, c, nr, nc);
          send_word(CMD_READ, IDX_W'(r), IDX_W'(c), $urandom, 1'b0, '0);
        end
      end
    end

    settle_block();
    if (lap_expected.size() != 0) begin
      $error("%0d expected results never arrived", lap_expected.size());
      errors++;
    end
    $display("covered %0d words (%0d reads, %0d writes) over %0d register writes",
             words_in, reads_in, writes_in, cfg_writes);
    $display("checked %0d results: %0d outside the size, %0d clamped; %0d errors",
             results_checked, outside_seen, saturated_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
